// File: sv/vlq_pkg.sv
// vlq_pkg: shared constants, types and group helpers for the vlq codec
// used by vlq_ctrl, vlq_dp and vlq_codec; no dependencies
package vlq_pkg;

  localparam int MaxGroups = 10;      // decode sequence limit, 2..10
  localparam int NumGroups = 10;      // 7-bit groups in a 64-bit value
  localparam int GrpW      = 7;
  localparam int CntW      = 4;

  // configuration register indexes
  localparam logic CfgEncodeMode   = 1'b0;
  localparam logic CfgLittleEndian = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } vlq_state_t;

  typedef struct packed {
    logic dec_step;   // decode the accepted byte
    logic enc_load;   // capture a value to encode
    logic enc_emit;   // put the next encoded byte in the output register
  } vlq_cmd_t;

  typedef struct packed {
    logic dec_res;    // accepted byte gives a result
    logic enc_last;   // next encoded byte is the final one
  } vlq_stat_t;

  function automatic logic [GrpW-1:0] get_group(input logic [63:0] v,
                                                 input logic [CntW-1:0] g);
    logic [NumGroups*GrpW-1:0] p;
    logic [GrpW-1:0] r;
    p = {{(NumGroups*GrpW-64){1'b0}}, v};
    r = '0;
    for (int i = 0; i < NumGroups; i++) begin
      if (g == CntW'(i)) r = p[GrpW*i +: GrpW];
    end
    return r;
  endfunction

  // number of groups to send: max(1, ceil(bits/7))
  function automatic logic [CntW-1:0] num_groups(input logic [63:0] v);
    logic [NumGroups*GrpW-1:0] p;
    logic [CntW-1:0] n;
    p = {{(NumGroups*GrpW-64){1'b0}}, v};
    n = CntW'(1);
    for (int i = 1; i < NumGroups; i++) begin
      if (p[GrpW*i +: GrpW] != '0) n = CntW'(i + 1);
    end
    return n;
  endfunction

endpackage

// File: sv/vlq_ctrl.sv
// vlq_ctrl: handshake and sequencing state machine of the vlq codec
// depends on vlq_pkg
module vlq_ctrl import vlq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      encode_mode,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  vlq_stat_t stat,
  output vlq_cmd_t  cmd
);

  vlq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (encode_mode) begin
            cmd.enc_load = 1'b1;
            state_nxt    = ST_ENC;
          end else begin
            cmd.dec_step = 1'b1;
            if (stat.dec_res) out_valid_nxt = 1'b1;
          end
        end
      end
      ST_ENC: begin
        if (slot_free) begin
          cmd.enc_emit  = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.enc_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_accept_enc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ENC |-> !in_ready)
    else $error("input taken while encoding");

  a_load_enters_enc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enc_load |=> state_r == ST_ENC && !out_valid_r)
    else $error("encode load did not start emission");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enc_emit && stat.enc_last |=> state_r == ST_IDLE && out_valid_r)
    else $error("final encoded word did not end the run");

endmodule

// File: sv/vlq_dp.sv
// vlq_dp: decode accumulator, encode shifter and output register
// depends on vlq_pkg
module vlq_dp import vlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        little_endian,
  input  vlq_cmd_t    cmd,
  output vlq_stat_t   stat,
  input  logic [63:0] in_data_in,
  input  logic        in_line_end,
  output logic [63:0] out_result_value,
  output logic        out_error_flag,
  output logic        out_last_of_run
);

  // decode state
  logic [63:0]     acc_r, acc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            skip_r, skip_nxt;
  // encode state
  logic [63:0]     val_r;
  logic [CntW-1:0] grp_r, rem_r;
  // output word
  logic [63:0]     res_val_r;
  logic            res_err_r, res_last_r;

  logic [GrpW-1:0] dgrp;
  logic            cont;
  logic [6:0]      sh;
  logic [63:0]     acc_new;
  logic            dec_res;
  logic [63:0]     dec_val;
  logic            dec_err;
  logic [CntW-1:0] n_grp;
  logic [7:0]      enc_byte;

  assign dgrp  = in_data_in[6:0];
  assign cont  = in_data_in[7];
  assign sh    = {cnt_r, 3'b000} - {3'b000, cnt_r};   // 7 * count
  assign n_grp = num_groups(in_data_in);

  always_comb begin
    acc_new  = little_endian ? (acc_r | ({57'd0, dgrp} << sh)) : {acc_r[56:0], dgrp};
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    skip_nxt = skip_r;
    dec_res  = 1'b0;
    dec_val  = '1;
    dec_err  = 1'b0;
    if (skip_r) begin
      if (in_line_end) skip_nxt = 1'b0;
    end else if (cnt_r >= CntW'(MaxGroups)) begin
      // too many groups: report and drop the sequence
      acc_nxt  = '0;
      cnt_nxt  = '0;
      skip_nxt = !in_line_end;
      dec_res  = 1'b1;
      dec_err  = 1'b1;
    end else if (!cont) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      skip_nxt = !in_line_end;
      dec_res  = 1'b1;
      dec_val  = acc_new;
    end else if (in_line_end) begin
      // line ended mid-sequence
      acc_nxt  = '0;
      cnt_nxt  = '0;
      dec_res  = 1'b1;
      dec_err  = 1'b1;
    end else begin
      acc_nxt  = acc_new;
      cnt_nxt  = cnt_r + CntW'(1);
    end
  end

  assign stat.dec_res  = dec_res;
  assign stat.enc_last = (rem_r == CntW'(1));
  assign enc_byte      = {!stat.enc_last, get_group(val_r, grp_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      skip_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      if (cmd.dec_step) begin
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        skip_r <= skip_nxt;
      end
      if (cmd.enc_load) begin
        rem_r <= n_grp;
      end else if (cmd.enc_emit) begin
        rem_r <= rem_r - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      val_r <= in_data_in;
      grp_r <= little_endian ? '0 : n_grp - CntW'(1);
    end else if (cmd.enc_emit) begin
      grp_r <= little_endian ? grp_r + CntW'(1) : grp_r - CntW'(1);
    end
    if (cmd.enc_emit) begin
      res_val_r  <= {56'd0, enc_byte};
      res_err_r  <= 1'b0;
      res_last_r <= stat.enc_last;
    end else if (cmd.dec_step && dec_res) begin
      res_val_r  <= dec_val;
      res_err_r  <= dec_err;
      res_last_r <= 1'b1;
    end
  end

  assign out_result_value = res_val_r;
  assign out_error_flag   = res_err_r;
  assign out_last_of_run  = res_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxGroups))
    else $error("group count beyond limit");

  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enc_emit |-> rem_r != '0)
    else $error("encoded word emitted with no groups left");

  a_skip_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_step && skip_r && in_line_end |=> !skip_r && cnt_r == '0)
    else $error("line end did not stop skipping");

endmodule

// File: sv/vlq_codec.sv
// decode: a value appears in the cycle after its last byte is taken; one
// byte per cycle while the output is free or being read; results wait in one
// output register; encode: a taken value puts the controller in its encode
// state, which emits one byte per cycle while the output is free or being read;
// n groups give n bytes; no input is taken until the last; reset: synchronous,
// active low; clears configuration, decode state and output valid; no clearing pass
module vlq_codec import vlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_in,
  input  logic        in_line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_value,
  output logic        out_error_flag,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic        cfg_data
);

  logic      encode_mode_r, little_endian_r;
  vlq_cmd_t  cmd;
  vlq_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encode_mode_r   <= 1'b0;
      little_endian_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CfgEncodeMode:   encode_mode_r   <= cfg_data;
        CfgLittleEndian: little_endian_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vlq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .encode_mode (encode_mode_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  vlq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .little_endian    (little_endian_r),
    .cmd              (cmd),
    .stat             (stat),
    .in_data_in       (in_data_in),
    .in_line_end      (in_line_end),
    .out_result_value (out_result_value),
    .out_error_flag   (out_error_flag),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
